// ===== hdl/tht_pkg.sv =====
// ----------------------------------------------------------------------------
// tht_pkg: shared types and constants for the token table lookup
// Key size, table geometry, request codes, channel items, the stored entry
// layout, the controller states and the byte hash step.
// ----------------------------------------------------------------------------
package tht_pkg;

  // Key geometry
  localparam int unsigned KEY_BYTES   = 16;
  localparam int unsigned TEXT_W      = 8 * KEY_BYTES;
  localparam int unsigned LEN_W       = $clog2(KEY_BYTES + 1);

  // Table geometry (fixed by the 8-bit hashes and entry index)
  localparam int unsigned TABLE_DEPTH = 256;
  localparam int unsigned ADDR_W      = 8;

  // Hash seeds
  localparam logic [7:0] SEED_ONE = 8'd0;
  localparam logic [7:0] SEED_TWO = 8'd23;

  // Request codes
  typedef enum logic [1:0] {
    REQ_LOAD  = 2'd0,
    REQ_TOKEN = 2'd1,
    REQ_END   = 2'd2
  } req_e;

  // Controller states
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_LOAD,
    ST_FIRST,
    ST_SECOND
  } state_e;

  // Input item
  typedef struct packed {
    logic [1:0] req_type;
    logic [7:0] data_byte;
    logic [7:0] entry_index;
    logic [3:0] byte_position;
    logic [4:0] entry_length;
  } in_item_t;

  // Result item
  typedef struct packed {
    logic       hit;
    logic [7:0] match_index;
  } out_item_t;

  // One table row as stored in memory
  typedef struct packed {
    logic [LEN_W-1:0]  len;
    logic [TEXT_W-1:0] text;
  } entry_t;

  localparam int unsigned ENTRY_W = $bits(entry_t);

  // One hash step: ((h ^ b) * 3) mod 256
  function automatic logic [7:0] mix_byte(logic [7:0] h, logic [7:0] b);
    logic [7:0] x;
    x = h ^ b;
    return x + {x[6:0], 1'b0};
  endfunction

endpackage

// ===== hdl/tht_ram.sv =====
// ----------------------------------------------------------------------------
// tht_ram: generic single-write, single-read RAM
// One write port and one read port; read data is registered and held while
// no read is issued.
// ----------------------------------------------------------------------------
module tht_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 256
) (
  input  logic                     clk_i,
  input  logic                     wr_en_i,
  input  logic [$clog2(DEPTH)-1:0] wr_addr_i,
  input  logic [WIDTH-1:0]         wr_data_i,
  input  logic                     rd_en_i,
  input  logic [$clog2(DEPTH)-1:0] rd_addr_i,
  output logic [WIDTH-1:0]         rd_data_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rd_data_q;

  // Write port
  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wr_addr_i] <= wr_data_i;
    end
  end

  // Registered read port
  always_ff @(posedge clk_i) begin
    if (rd_en_i) begin
      rd_data_q <= mem_q[rd_addr_i];
    end
  end

  assign rd_data_o = rd_data_q;

endmodule

// ===== hdl/tht_match.sv =====
// ----------------------------------------------------------------------------
// tht_match: shared entry compare unit
// Compares one table row with the kept token: lengths must be equal and the
// bytes below that length must be equal. Used once per probe.
// ----------------------------------------------------------------------------
module tht_match (
  input  tht_pkg::entry_t                  entry_i,
  input  logic [tht_pkg::TEXT_W-1:0]       token_i,
  input  logic [tht_pkg::LEN_W-1:0]        count_i,
  output logic                             match_o
);

  always_comb begin
    logic eq;
    eq = (entry_i.len == count_i);
    // Check only the bytes inside the token length
    for (int i = 0; i < tht_pkg::KEY_BYTES; i++) begin
      if ((tht_pkg::LEN_W'(i) < count_i) &&
          (entry_i.text[8*i +: 8] != token_i[8*i +: 8])) begin
        eq = 1'b0;
      end
    end
    match_o = eq;
  end

endmodule

// ===== hdl/two_hash_token_table_lookup.sv =====
// ----------------------------------------------------------------------------
// two_hash_token_table_lookup: two-choice hash lookup of short tokens
// Holds a 256-entry table of strings (up to KEY_BYTES bytes plus length).
// Token bytes drive two 8-bit hashes; a token end probes the table at both
// hashes through one memory read port and one shared compare unit.
//
//   channel | direction | handshake            | payload
//   --------+-----------+----------------------+----------------------------
//   in      | input     | in_valid_i/in_stall_o   | tht_pkg::in_item_t
//   out     | output    | out_valid_o/out_stall_i | tht_pkg::out_item_t
//
// Steps: a token byte is taken directly, a load reads the row and then writes
// the merged row, a token end probes the first hash, probes the second hash
// and emits, all paced by the single registered read port of the table RAM.
// A token end waits in ST_SECOND while an earlier result is stalled.
// Reset clears the row valid bits at once: no clearing pass, rows not yet
// loaded read as empty strings.
// ----------------------------------------------------------------------------
module two_hash_token_table_lookup (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_stall_o,
  input  tht_pkg::in_item_t    in_data_i,
  output logic                 out_valid_o,
  input  logic                 out_stall_i,
  output tht_pkg::out_item_t   out_data_o
);

  tht_pkg::state_e                  state_q, state_d;
  tht_pkg::in_item_t                ld_q;
  logic [tht_pkg::TABLE_DEPTH-1:0]  valid_q;
  logic                             rd_vld_q;
  logic [7:0]                       hash_one_q, hash_two_q;
  logic [tht_pkg::TEXT_W-1:0]       tok_text_q;
  logic [tht_pkg::LEN_W-1:0]        tok_count_q;
  logic                             hit1_q;
  logic                             out_valid_q;
  tht_pkg::out_item_t               out_data_q;

  logic                             in_xfer;
  logic                             out_free;
  logic                             finish;
  logic                             rd_en;
  logic [tht_pkg::ADDR_W-1:0]       rd_addr;
  logic                             wr_en;
  logic [tht_pkg::ENTRY_W-1:0]      rd_data;
  tht_pkg::entry_t                  row_eff;
  tht_pkg::entry_t                  row_new;
  logic                             match;

  assign in_stall_o = (state_q != tht_pkg::ST_IDLE);
  assign in_xfer    = in_valid_i && !in_stall_o;
  assign out_free   = !out_valid_q || !out_stall_i;
  assign finish     = (state_q == tht_pkg::ST_SECOND) && out_free;

  // Next state and memory control
  always_comb begin
    state_d = state_q;
    rd_en   = 1'b0;
    rd_addr = in_data_i.entry_index;
    wr_en   = 1'b0;
    unique case (state_q)
      tht_pkg::ST_IDLE: begin
        if (in_xfer) begin
          case (in_data_i.req_type)
            tht_pkg::REQ_LOAD: begin
              rd_en   = 1'b1;
              rd_addr = in_data_i.entry_index;
              state_d = tht_pkg::ST_LOAD;
            end
            tht_pkg::REQ_END: begin
              rd_en   = 1'b1;
              rd_addr = hash_one_q;
              state_d = tht_pkg::ST_FIRST;
            end
            default: ;
          endcase
        end
      end
      tht_pkg::ST_LOAD: begin
        wr_en   = 1'b1;
        state_d = tht_pkg::ST_IDLE;
      end
      tht_pkg::ST_FIRST: begin
        rd_en   = 1'b1;
        rd_addr = hash_two_q;
        state_d = tht_pkg::ST_SECOND;
      end
      tht_pkg::ST_SECOND: begin
        if (out_free) begin
          state_d = tht_pkg::ST_IDLE;
        end
      end
      default: state_d = tht_pkg::ST_IDLE;
    endcase
  end

  // State register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= tht_pkg::ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // Table memory: text and length of each row
  tht_ram #(
    .WIDTH(tht_pkg::ENTRY_W),
    .DEPTH(tht_pkg::TABLE_DEPTH)
  ) u_table (
    .clk_i    (clk_i),
    .wr_en_i  (wr_en),
    .wr_addr_i(ld_q.entry_index),
    .wr_data_i(row_new),
    .rd_en_i  (rd_en),
    .rd_addr_i(rd_addr),
    .rd_data_o(rd_data)
  );

  // Rows never loaded read as empty
  assign row_eff = rd_vld_q ? tht_pkg::entry_t'(rd_data) : '0;

  // Merge the load byte and saturated length into the row
  always_comb begin
    row_new = row_eff;
    for (int i = 0; i < tht_pkg::KEY_BYTES; i++) begin
      if (32'(ld_q.byte_position) == i) begin
        row_new.text[8*i +: 8] = ld_q.data_byte;
      end
    end
    if (32'(ld_q.entry_length) > tht_pkg::KEY_BYTES) begin
      row_new.len = tht_pkg::LEN_W'(tht_pkg::KEY_BYTES);
    end else begin
      row_new.len = tht_pkg::LEN_W'(ld_q.entry_length);
    end
  end

  // Capture the load item
  always_ff @(posedge clk_i) begin
    if (in_xfer) begin
      ld_q <= in_data_i;
    end
  end

  // Row valid bits and the valid flag of the row being read
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q  <= '0;
      rd_vld_q <= 1'b0;
    end else begin
      if (wr_en) begin
        valid_q[ld_q.entry_index] <= 1'b1;
      end
      if (rd_en) begin
        rd_vld_q <= valid_q[rd_addr];
      end
    end
  end

  // Shared compare unit, used for the first and then the second probe
  tht_match u_match (
    .entry_i(row_eff),
    .token_i(tok_text_q),
    .count_i(tok_count_q),
    .match_o(match)
  );

  // Hashes and kept token: advance on token bytes, clear after a lookup
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hash_one_q  <= tht_pkg::SEED_ONE;
      hash_two_q  <= tht_pkg::SEED_TWO;
      tok_text_q  <= '0;
      tok_count_q <= '0;
    end else if (finish) begin
      hash_one_q  <= tht_pkg::SEED_ONE;
      hash_two_q  <= tht_pkg::SEED_TWO;
      tok_text_q  <= '0;
      tok_count_q <= '0;
    end else if (in_xfer && (in_data_i.req_type == tht_pkg::REQ_TOKEN)) begin
      hash_one_q <= tht_pkg::mix_byte(hash_one_q, in_data_i.data_byte);
      hash_two_q <= tht_pkg::mix_byte(hash_two_q, in_data_i.data_byte);
      if (tok_count_q < tht_pkg::LEN_W'(tht_pkg::KEY_BYTES)) begin
        for (int i = 0; i < tht_pkg::KEY_BYTES; i++) begin
          if (tht_pkg::LEN_W'(i) == tok_count_q) begin
            tok_text_q[8*i +: 8] <= in_data_i.data_byte;
          end
        end
        tok_count_q <= tok_count_q + 1'b1;
      end
    end
  end

  // Hold the first probe outcome
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hit1_q <= 1'b0;
    end else if (state_q == tht_pkg::ST_FIRST) begin
      hit1_q <= match;
    end
  end

  // Output register: load on lookup finish, drop on transfer
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (finish) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (finish) begin
      if (hit1_q) begin
        out_data_q.hit         <= 1'b1;
        out_data_q.match_index <= hash_one_q;
      end else if (match) begin
        out_data_q.hit         <= 1'b1;
        out_data_q.match_index <= hash_two_q;
      end else begin
        out_data_q.hit         <= 1'b0;
        out_data_q.match_index <= '0;
      end
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

  // A finished lookup always leaves a result behind
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    finish |=> out_valid_q)
    else $error("lookup finished without a result");

  // The token state is back at its seeds after a lookup
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    finish |=> (hash_one_q == tht_pkg::SEED_ONE) && (hash_two_q == tht_pkg::SEED_TWO)
               && (tok_count_q == '0))
    else $error("token state not cleared after lookup");

  // The table is never written and read in the same cycle
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(wr_en && rd_en))
    else $error("table read and write collide");

  // A miss reports index zero
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && !out_data_q.hit) |-> (out_data_q.match_index == '0))
    else $error("miss with nonzero index");

endmodule
